### src/latency_stability_monitor_core_defines.svh
// Assertion macros shared by the monitor RTL
`ifndef LATENCY_STABILITY_MONITOR_CORE_DEFINES_SVH
`define LATENCY_STABILITY_MONITOR_CORE_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle
`define LSM_ASSERT_IMP(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define LSM_ASSERT_NXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

### src/lsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsm_pkg
// Types and constants shared by the latency stability monitor.
// ----------------------------------------------------------------------------
package lsm_pkg;
    localparam int LatBits  = 24;
    localparam int FracBits = 16;
    localparam int MeanBits = LatBits + FracBits;
    localparam int CvBits   = 17;
    localparam logic [CvBits-1:0] CvOne = 17'h10000;

    localparam logic [1:0] REG_BURN   = 2'd0;
    localparam logic [1:0] REG_MINS   = 2'd1;
    localparam logic [1:0] REG_STABLE = 2'd2;
    localparam logic [1:0] REG_THRESH = 2'd3;

    // Shared unit operations
    typedef enum logic [1:0] {
        OP_DIV  = 2'd0,
        OP_SQRT = 2'd1,
        OP_MUL  = 2'd2
    } op_t;

    typedef struct packed {
        logic        start;
        op_t         op;
        logic [63:0] a;
        logic [63:0] b;
    } unit_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] q;
        logic [63:0] hi;
    } unit_rsp_t;
endpackage

### src/lsm_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsm_unit
// Shared bit-serial unit: 64/64 divide, 128-bit root, 64x64 multiply.
// One bit per cycle.
// ----------------------------------------------------------------------------
module lsm_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  lsm_pkg::unit_req_t req,
    output lsm_pkg::unit_rsp_t rsp
);
    import lsm_pkg::*;

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    op_t         op_reg, op_next;
    logic [63:0] a_reg, a_next;     // dividend / radicand low / multiplier
    logic [63:0] b_reg, b_next;     // divisor / radicand high / multiplicand
    logic [65:0] rem_reg, rem_next;
    logic [63:0] q_reg, q_next;     // quotient / root / product low
    logic [63:0] hi_reg, hi_next;   // product high
    logic        done_reg, done_next;

    logic [65:0] dtrial;
    logic [65:0] srem;
    logic [65:0] strial;
    logic [64:0] psum;

    always_comb
    begin
        dtrial = {rem_reg[64:0], a_reg[63]} - {2'b00, b_reg};
        srem   = {rem_reg[63:0], b_reg[63:62]};
        strial = {q_reg, 2'b01};
        psum   = {1'b0, hi_reg} + ((a_reg[0]) ? {1'b0, b_reg} : 65'd0);
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        hi_next   = hi_reg;
        done_next = 1'b0;
        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next = 1'b1;
                cnt_next  = 6'd0;
                op_next   = req.op;
                a_next    = req.a;
                b_next    = req.b;
                rem_next  = '0;
                q_next    = '0;
                hi_next   = '0;
            end
        end
        else
        begin
            unique case (op_reg)
                OP_DIV:
                begin
                    a_next = {a_reg[62:0], 1'b0};
                    if (!dtrial[65])
                    begin
                        rem_next = dtrial;
                        q_next   = {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = {rem_reg[64:0], a_reg[63]};
                        q_next   = {q_reg[62:0], 1'b0};
                    end
                end
                OP_SQRT:
                begin
                    // radicand bits stream from b (high) then a (low)
                    b_next = {b_reg[61:0], a_reg[63:62]};
                    a_next = {a_reg[61:0], 2'b00};
                    if (srem >= strial)
                    begin
                        rem_next = srem - strial;
                        q_next   = {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = srem;
                        q_next   = {q_reg[62:0], 1'b0};
                    end
                end
                OP_MUL:
                begin
                    // shift-add: product high in hi, low bits shift into q
                    hi_next = psum[64:1];
                    q_next  = {psum[0], q_reg[63:1]};
                    a_next  = {1'b0, a_reg[63:1]};
                end
                default:
                begin
                    q_next = q_reg;
                end
            endcase
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            op_reg   <= OP_DIV;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        hi_reg  <= hi_next;
    end

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;
    assign rsp.hi   = hi_reg;
endmodule

### src/latency_stability_monitor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_stability_monitor_core
// Welford mean/variance tracker with CV-based settle detection.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per latency sample: tdata[23:0] latency,
//   tuser restart. m_axis returns one result per request. Registers are
//   written through cfg_we/cfg_addr/cfg_wdata while idle (user-enforced).
// Sequence:
//   A statistic sample runs through one shared bit-serial unit in turn:
//   divide for the mean, multiply for the squared deviation, divide by
//   n-1, square root, divide for the CV. Burn-in samples and samples
//   with n < 2 or a zero mean skip the unneeded operations; a standard
//   deviation at or above the mean skips the CV divide.
//   s_axis_tready is high whenever the sequencer is idle, so one request
//   is computed at a time.
// Reset:
//   All statistics clear, the minimum goes to all ones, registers take
//   burn_in 5, min_samples 5, stable_needed 5, threshold 1966.
// Stall:
//   A result holds in the output register until m_axis_tready. One more
//   request may be taken and computed meanwhile; it then holds in the
//   final step until the output register frees.
// ----------------------------------------------------------------------------
`include "latency_stability_monitor_core_defines.svh"
module latency_stability_monitor_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,   // [23:0] latency
    input  logic         s_axis_tuser,   // [0] restart
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [15:0] sample_count, [55:16] mean_latency, [79:56] min_latency,
    // [96:80] variation, [104:97] stable_run, [111:105] zero fill
    output logic [111:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // [0] burning_in, [1] settled
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [16:0]  cfg_wdata
);
    import lsm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MEANDIV, S_MEANUPD, S_MUL, S_ACC, S_CVCHK,
        S_VARDIV, S_SQRT, S_CVDIV, S_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [7:0]        burn_reg, burn_next;
    logic [15:0]       count_reg, count_next;
    logic [MeanBits-1:0] mean_reg, mean_next;
    logic [63:0]       sq_reg, sq_next;
    logic [LatBits-1:0] min_reg, min_next;
    logic [7:0]        run_reg, run_next;
    logic [7:0]        cfg_burn_reg;
    logic [15:0]       cfg_mins_reg;
    logic [7:0]        cfg_stable_reg;
    logic [16:0]       cfg_thresh_reg;
    logic [LatBits-1:0] lat_reg, lat_next;
    logic              up_reg, up_next;
    logic [MeanBits-1:0] mag_reg, mag_next;
    logic              burning_reg, burning_next;
    logic [CvBits-1:0] cv_reg, cv_next;
    logic              ovalid_reg, ovalid_next;
    logic [111:0]      odata_reg, odata_next;
    logic [1:0]        ouser_reg, ouser_next;
    unit_req_t         ureq;
    unit_rsp_t         ursp;

    logic [MeanBits-1:0] x_ext;
    logic [MeanBits-1:0] mag2;
    logic [63:0]       prod;
    logic [64:0]       acc;
    logic [63:0]       sd;

    lsm_unit u_unit (.clk(clk), .rst_n(rst_n), .req(ureq), .rsp(ursp));

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ouser_reg;

    always_comb
    begin
        x_ext = {lat_reg, {FracBits{1'b0}}};
        mag2  = up_reg ? (x_ext - mean_reg) : (mean_reg - x_ext);
        if (ursp.hi[63:FracBits] != '0)
            prod = '1;
        else
            prod = {ursp.hi[FracBits-1:0], ursp.q[63:FracBits]};
        acc = {1'b0, sq_reg} + {1'b0, prod};
        sd  = ursp.q;
    end

    always_comb
    begin
        state_next   = state_reg;
        burn_next    = burn_reg;
        count_next   = count_reg;
        mean_next    = mean_reg;
        sq_next      = sq_reg;
        min_next     = min_reg;
        run_next     = run_reg;
        lat_next     = lat_reg;
        up_next      = up_reg;
        mag_next     = mag_reg;
        burning_next = burning_reg;
        cv_next      = cv_reg;
        ovalid_next  = ovalid_reg;
        odata_next   = odata_reg;
        ouser_next   = ouser_reg;
        ureq         = '{start: 1'b0, op: OP_DIV, a: '0, b: '0};
        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    lat_next = s_axis_tdata;
                    if (s_axis_tuser)
                    begin
                        burn_next  = '0;
                        count_next = '0;
                        mean_next  = '0;
                        sq_next    = '0;
                        min_next   = '1;
                        run_next   = '0;
                    end
                    if ((s_axis_tuser ? 8'd0 : burn_reg) < cfg_burn_reg)
                    begin
                        burn_next    = (s_axis_tuser ? 8'd0 : burn_reg) + 8'd1;
                        burning_next = 1'b1;
                        state_next   = S_CVCHK;
                    end
                    else
                    begin
                        burning_next = 1'b0;
                        state_next   = S_MEANDIV;
                    end
                end
            end
            S_MEANDIV:
            begin
                if (count_reg != 16'hFFFF)
                    count_next = count_reg + 16'd1;
                up_next  = x_ext >= mean_reg;
                mag_next = (x_ext >= mean_reg) ? (x_ext - mean_reg) : (mean_reg - x_ext);
                ureq = '{start: 1'b1, op: OP_DIV,
                         a: {24'd0, ((x_ext >= mean_reg) ? (x_ext - mean_reg)
                                                         : (mean_reg - x_ext))},
                         b: {48'd0, ((count_reg != 16'hFFFF) ? count_reg + 16'd1
                                                             : count_reg)}};
                if (lat_reg < min_reg)
                    min_next = lat_reg;
                state_next = S_MEANUPD;
            end
            S_MEANUPD:
            begin
                if (ursp.done)
                begin
                    mean_next = up_reg ? mean_reg + ursp.q[MeanBits-1:0]
                                       : mean_reg - ursp.q[MeanBits-1:0];
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                ureq = '{start: 1'b1, op: OP_MUL, a: {24'd0, mag_reg}, b: {24'd0, mag2}};
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (ursp.done)
                begin
                    sq_next    = acc[64] ? '1 : acc[63:0];
                    state_next = S_CVCHK;
                end
            end
            S_CVCHK:
            begin
                if (count_reg < 16'd2 || mean_reg == '0)
                begin
                    cv_next    = CvOne;
                    state_next = S_FINISH;
                end
                else
                begin
                    ureq = '{start: 1'b1, op: OP_DIV, a: sq_reg,
                             b: {48'd0, count_reg - 16'd1}};
                    state_next = S_VARDIV;
                end
            end
            S_VARDIV:
            begin
                if (ursp.done)
                begin
                    ureq = '{start: 1'b1, op: OP_SQRT,
                             a: {ursp.q[63-FracBits:0], {FracBits{1'b0}}},
                             b: {{(64-FracBits){1'b0}}, ursp.q[63:64-FracBits]}};
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (ursp.done)
                begin
                    if (sd >= {24'd0, mean_reg})
                    begin
                        cv_next    = CvOne;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        // sd < mean < 2^40, so sd << 16 fits
                        ureq = '{start: 1'b1, op: OP_DIV, a: {sd[47:0], 16'd0},
                                 b: {24'd0, mean_reg}};
                        state_next = S_CVDIV;
                    end
                end
            end
            S_CVDIV:
            begin
                if (ursp.done)
                begin
                    cv_next    = ursp.q[CvBits-1:0];
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // hold until the output register frees
                if (!ovalid_reg || m_axis_tready)
                begin
                    if (!burning_reg)
                    begin
                        if (count_reg >= cfg_mins_reg && cv_reg < cfg_thresh_reg)
                        begin
                            if (run_reg != 8'hFF)
                                run_next = run_reg + 8'd1;
                        end
                        else
                            run_next = '0;
                    end
                    ovalid_next = 1'b1;
                    odata_next  = {7'd0, run_next, cv_reg, min_reg, mean_reg, count_reg};
                    ouser_next  = {(run_next >= cfg_stable_reg), burning_reg};
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            burn_reg       <= '0;
            count_reg      <= '0;
            mean_reg       <= '0;
            sq_reg         <= '0;
            min_reg        <= '1;
            run_reg        <= '0;
            ovalid_reg     <= 1'b0;
            burning_reg    <= 1'b0;
            cfg_burn_reg   <= 8'd5;
            cfg_mins_reg   <= 16'd5;
            cfg_stable_reg <= 8'd5;
            cfg_thresh_reg <= 17'd1966;
        end
        else
        begin
            state_reg   <= state_next;
            burn_reg    <= burn_next;
            count_reg   <= count_next;
            mean_reg    <= mean_next;
            sq_reg      <= sq_next;
            min_reg     <= min_next;
            run_reg     <= run_next;
            ovalid_reg  <= ovalid_next;
            burning_reg <= burning_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_BURN:   cfg_burn_reg   <= cfg_wdata[7:0];
                    REG_MINS:   cfg_mins_reg   <= cfg_wdata[15:0];
                    REG_STABLE: cfg_stable_reg <= cfg_wdata[7:0];
                    REG_THRESH: cfg_thresh_reg <= cfg_wdata;
                    default:    cfg_burn_reg   <= cfg_burn_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lat_reg   <= lat_next;
        up_reg    <= up_next;
        mag_reg   <= mag_next;
        cv_reg    <= cv_next;
        odata_reg <= odata_next;
        ouser_reg <= ouser_next;
    end

    `LSM_ASSERT_IMP(a_ready_idle, clk, rst_n, s_axis_tready, state_reg == S_IDLE, "ready outside idle")
    `LSM_ASSERT_IMP(a_cv_range, clk, rst_n, m_axis_tvalid, m_axis_tdata[96:80] <= CvOne, "cv above one")
    `LSM_ASSERT_NXT(a_finish_out, clk, rst_n, state_reg == S_FINISH, m_axis_tvalid, "result missing")
    `LSM_ASSERT_IMP(a_burn_nocnt, clk, rst_n, state_reg == S_MEANDIV, !burning_reg, "stat on burn-in")
endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Latency stability monitor testbench: a directed table of latency requests
// followed by random series under several register settings. Each request
// updates an internal Welford mean/variance model, and every result is
// compared field by field in arrival order. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import lsm_pkg::*;

    localparam int CYCLE_LIMIT = 5_000_000;

    typedef struct packed {
        logic        burning;
        logic [15:0] count;
        logic [39:0] mean;
        logic [23:0] min_lat;
        logic [16:0] cv;
        logic [7:0]  run;
        logic        settled;
    } lat_stat_t;

    typedef struct packed {
        logic [23:0] lat;
        logic        restart;
        logic        typed;
        lat_stat_t   res;
    } dir_row_t;

    localparam lat_stat_t BURN_RES = '{1'b1, 16'd0, 40'd0, 24'hFFFFFF, 17'h10000, 8'd0, 1'b0};
    localparam lat_stat_t NO_RES   = '0;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [23:0]  s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         cfg_we;
    logic [1:0]   cfg_addr;
    logic [16:0]  cfg_wdata;

    latency_stability_monitor_core dut (.*);

    // model registers and state
    logic [7:0]  burn_cfg;
    logic [15:0] mins_cfg;
    logic [7:0]  stable_cfg;
    logic [16:0] thresh_cfg;
    logic [7:0]  burn_cnt;
    logic [15:0] stat_cnt;
    logic [39:0] mean_acc;
    logic [63:0] sq_dev;
    logic [23:0] min_seen;
    logic [7:0]  run_len;

    lat_stat_t expected_q[$];
    int  mismatches = 0;
    int  req_count = 0;
    int  res_count = 0;
    int  settled_count = 0;
    int  cfg_count = 0;
    longint cycles = 0;
    bit  calm = 0;
    bit  hold_go = 0;
    bit  hold_used = 0;
    int  hold_left = 0;

    dir_row_t dir_tab [0:22] = '{
        '{24'd10,       1'b0, 1'b1, BURN_RES},
        '{24'd20,       1'b0, 1'b1, BURN_RES},
        '{24'd30,       1'b0, 1'b1, BURN_RES},
        '{24'd40,       1'b0, 1'b1, BURN_RES},
        '{24'd50,       1'b0, 1'b1, BURN_RES},
        '{24'd1000,     1'b0, 1'b1,
          '{1'b0, 16'd1, 40'd65536000, 24'd1000, 17'h10000, 8'd0, 1'b0}},
        '{24'd1000,     1'b0, 1'b0, NO_RES},
        '{24'hFFFFFF,   1'b0, 1'b0, NO_RES},
        '{24'd0,        1'b0, 1'b0, NO_RES},
        '{24'd0,        1'b0, 1'b0, NO_RES},
        '{24'd5,        1'b1, 1'b1, BURN_RES},
        '{24'd7,        1'b0, 1'b1, BURN_RES},
        '{24'd7,        1'b0, 1'b1, BURN_RES},
        '{24'd7,        1'b0, 1'b1, BURN_RES},
        '{24'd7,        1'b0, 1'b1, BURN_RES},
        '{24'd0,        1'b0, 1'b1,
          '{1'b0, 16'd1, 40'd0, 24'd0, 17'h10000, 8'd0, 1'b0}},
        '{24'd0,        1'b0, 1'b1,
          '{1'b0, 16'd2, 40'd0, 24'd0, 17'h10000, 8'd0, 1'b0}},
        '{24'd500,      1'b0, 1'b0, NO_RES},
        '{24'd500,      1'b0, 1'b0, NO_RES},
        '{24'd500,      1'b0, 1'b0, NO_RES},
        '{24'd500,      1'b0, 1'b0, NO_RES},
        '{24'd500,      1'b0, 1'b0, NO_RES},
        '{24'hFFFFFF,   1'b1, 1'b1, BURN_RES}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor(sqrt(v << 16)), one result bit per step
    function automatic logic [63:0] scaled_root(logic [63:0] v);
        logic [127:0] rad;
        logic [127:0] rem;
        logic [127:0] trial;
        logic [63:0]  root;
        rad  = {64'd0, v} << FracBits;
        rem  = '0;
        root = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem   = (rem << 2) | rad[2*i +: 2];
            trial = ({64'd0, root} << 2) | 128'd1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    function automatic logic [16:0] variation_now();
        logic [63:0] var_q;
        logic [63:0] sd;
        logic [63:0] mean64;
        if (stat_cnt < 16'd2 || mean_acc == '0)
            return CvOne;
        mean64 = {24'd0, mean_acc};
        var_q  = sq_dev / {48'd0, stat_cnt - 16'd1};
        sd     = scaled_root(var_q);
        if (sd >= mean64)
            return CvOne;
        return 17'((sd << 16) / mean64);
    endfunction

    task automatic clear_stats();
        burn_cnt = '0;
        stat_cnt = '0;
        mean_acc = '0;
        sq_dev   = '0;
        min_seen = '1;
        run_len  = '0;
    endtask

    task automatic stat_update(logic [23:0] lat);
        logic [63:0]  x;
        logic [63:0]  mean64;
        logic [63:0]  mag;
        logic [63:0]  mag2;
        logic [63:0]  prod;
        logic [127:0] wide;
        logic [64:0]  sum;
        logic         up;
        x      = {24'd0, lat, 16'd0};
        mean64 = {24'd0, mean_acc};
        up     = x >= mean64;
        if (stat_cnt != 16'hFFFF)
            stat_cnt++;
        mag      = up ? x - mean64 : mean64 - x;
        mean64   = up ? mean64 + mag / stat_cnt : mean64 - mag / stat_cnt;
        mean_acc = mean64[39:0];
        mean64   = {24'd0, mean_acc};
        mag2     = up ? x - mean64 : mean64 - x;
        wide     = {64'd0, mag} * {64'd0, mag2};
        prod     = (wide[127:80] != '0) ? '1 : wide[79:16];
        sum      = {1'b0, sq_dev} + {1'b0, prod};
        sq_dev   = sum[64] ? '1 : sum[63:0];
        if (lat < min_seen)
            min_seen = lat;
    endtask

    // advance the model by one request and return its result
    task automatic predict_stats(input logic [23:0] lat, input logic restart,
                                 output lat_stat_t res);
        if (restart)
            clear_stats();
        res = '0;
        if (burn_cnt < burn_cfg)
        begin
            burn_cnt++;
            res.burning = 1'b1;
            res.cv = variation_now();
        end
        else
        begin
            stat_update(lat);
            res.cv = variation_now();
            if (stat_cnt >= mins_cfg && res.cv < thresh_cfg)
            begin
                if (run_len != 8'hFF)
                    run_len++;
            end
            else
                run_len = '0;
        end
        res.count   = stat_cnt;
        res.mean    = mean_acc;
        res.min_lat = min_seen;
        res.run     = run_len;
        res.settled = run_len >= stable_cfg;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_BURN:   burn_cfg   = val[7:0];
            REG_MINS:   mins_cfg   = val[15:0];
            REG_STABLE: stable_cfg = val[7:0];
            default:    thresh_cfg = val;
        endcase
        cfg_count++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_latency(logic [23:0] lat, logic restart, logic typed,
                                lat_stat_t typed_res);
        lat_stat_t res;
        while (!calm && $urandom_range(0, 99) < 32)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= lat;
        s_axis_tuser  <= restart;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_stats(lat, restart, res);
        expected_q.push_back(typed ? typed_res : res);
        req_count++;
        @(negedge clk);
    endtask

    task automatic random_phase(int n_items);
        int left;
        int len;
        logic [23:0] base;
        logic [23:0] jit;
        logic [23:0] lat;
        left = n_items;
        while (left > 0)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_latency(24'($urandom), $urandom_range(0, 19) == 0, 1'b0, NO_RES);
                left--;
            end
            else
            begin
                // a steady series at or just above a random base
                base = 24'($urandom) >> $urandom_range(0, 23);
                jit  = ($urandom_range(0, 3) == 0) ? base >> 2 : base >> 7;
                len  = $urandom_range(10, 50);
                for (int k = 0; k < len && left > 0; k++)
                begin
                    lat = base + 24'($urandom_range(0, 32'(jit)));
                    send_latency(lat, k == 0 && $urandom_range(0, 1) == 0, 1'b0, NO_RES);
                    left--;
                end
                if ($urandom_range(0, 7) == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    wait_drained();
                end
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic set_regs(logic [7:0] b, logic [15:0] m, logic [7:0] s, logic [16:0] t);
        wait_drained();
        write_reg(REG_BURN, {9'd0, b});
        write_reg(REG_MINS, {1'b0, m});
        write_reg(REG_STABLE, {9'd0, s});
        write_reg(REG_THRESH, t);
    endtask

    // receiver: random stalls plus one long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = 600;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= calm || $urandom_range(0, 99) >= 32;
        end
    end

    always @(posedge clk)
    begin
        lat_stat_t got;
        lat_stat_t exp_res;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.burning = m_axis_tuser[0];
            got.settled = m_axis_tuser[1];
            got.count   = m_axis_tdata[15:0];
            got.mean    = m_axis_tdata[55:16];
            got.min_lat = m_axis_tdata[79:56];
            got.cv      = m_axis_tdata[96:80];
            got.run     = m_axis_tdata[104:97];
            res_count++;
            if (got.settled)
                settled_count++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with nothing expected", res_count);
            end
            else
            begin
                exp_res = expected_q.pop_front();
                if (got !== exp_res)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: exp burn=%0d cnt=%0d mean=%0h min=%0h ",
                                  "cv=%0d run=%0d set=%0d / got burn=%0d cnt=%0d mean=%0h ",
                                  "min=%0h cv=%0d run=%0d set=%0d"}, res_count,
                                 exp_res.burning, exp_res.count, exp_res.mean,
                                 exp_res.min_lat, exp_res.cv, exp_res.run, exp_res.settled,
                                 got.burning, got.count, got.mean, got.min_lat, got.cv,
                                 got.run, got.settled);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = REG_BURN;
        cfg_wdata     = '0;
        burn_cfg      = 8'd5;
        mins_cfg      = 16'd5;
        stable_cfg    = 8'd5;
        thresh_cfg    = 17'd1966;
        clear_stats();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
            send_latency(dir_tab[i].lat, dir_tab[i].restart, dir_tab[i].typed, dir_tab[i].res);
        s_axis_tvalid <= 1'b0;

        set_regs(8'd0, 16'd2, 8'd1, 17'd65536);
        hold_go = 1'b1;
        random_phase(170);
        set_regs(8'd3, 16'd0, 8'd0, 17'd131071);
        random_phase(150);
        set_regs(8'd255, 16'd65535, 8'd255, 17'd0);
        random_phase(300);
        // lowered below the running burn-in count: burn-in ends at once
        set_regs(8'd1, 16'd1, 8'd255, 17'd6000);
        random_phase(150);
        set_regs(8'd10, 16'd8, 8'd4, 17'd3000);
        calm = 1'b1;
        random_phase(80);
        calm = 1'b0;
        random_phase(80);
        set_regs(8'd5, 16'd5, 8'd5, 17'd1966);
        random_phase(150);

        wait_drained();
        repeat (50) @(negedge clk);
        $display("%0d requests, %0d results (%0d settled), %0d register writes",
                 req_count, res_count, settled_count, cfg_count);
        $display("covered burn-in, restart, CV extremes and threshold settings 0..131071");
        if (mismatches == 0 && expected_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
